[rtl/core/sjf_pkg.sv]
// Shared types and constants for the shortest-job-first scheduler.
// Holds the request codes, the stream field widths and the controller/datapath
// command and status structs. Depends on nothing.
package sjf_pkg;

   // Request kinds carried on req_tuser.
   localparam logic REQ_ARRIVE = 1'b0;
   localparam logic REQ_TICK   = 1'b1;

   // Fixed field widths of the stream payloads.
   localparam int unsigned ID_W       = 8;
   localparam int unsigned IN_BURST_W = 16;
   localparam int unsigned OUT_W      = 32;
   localparam int unsigned REQ_DATA_W = 24;
   localparam int unsigned RSP_DATA_W = 112;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;         // latch the request payload
      logic scan_start;   // rewind the table pointer for a minimum search
      logic scan;         // walk the table looking for the shortest burst
      logic shift_start;  // point just past the chosen entry
      logic shift;        // close the gap left by the chosen entry
      logic pick;         // move the chosen entry into the running slot
      logic arrive;       // commit an arrival and load its result
      logic serve;        // advance time, serve the running job, load result
   } sjf_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic cur_valid;    // a job occupies the running slot
      logic empty;        // ready table holds no job
      logic walk_done;    // table walk has issued and retired every read
      logic out_free;     // output register can take a result this cycle
   } sjf_stat_type;

endpackage

[rtl/core/sjf_ctrl.sv]
// Controller state machine of the shortest-job-first scheduler.
// Sequences arrival, table scan, table compaction and service steps.
// Depends on sjf_pkg for the command and status structs.
module sjf_ctrl
   import sjf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tuser,
   output logic         req_tready,
   input  sjf_stat_type stat,
   output sjf_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_ARRIVE = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_SHIFT  = 3'd3;
   localparam logic [2:0] S_SERVE  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       take;

   assign req_tready = (state_ff == S_IDLE);
   assign take       = req_tvalid && req_tready;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               cmd.take = 1'b1;
               if (req_tuser == REQ_ARRIVE) begin
                  state_in = S_ARRIVE;
               end else if (stat.cur_valid || stat.empty) begin
                  state_in = S_SERVE;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in       = S_SCAN;
               end
            end
         end
         S_ARRIVE: begin
            cmd.arrive = stat.out_free;
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.walk_done) begin
               cmd.shift_start = 1'b1;
               state_in        = S_SHIFT;
            end
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            if (stat.walk_done) begin
               cmd.pick = 1'b1;
               state_in = S_SERVE;
            end
         end
         S_SERVE: begin
            cmd.serve = stat.out_free;
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/core/sjf_dpath.sv]
// Datapath of the shortest-job-first scheduler: ready table memory, minimum
// search, compaction, running slot, time counter and output register.
// Depends on sjf_pkg for widths and the command and status structs.
module sjf_dpath
   import sjf_pkg::*;
#(
   parameter int unsigned MAX_JOBS   = 16,
   parameter int unsigned BURST_BITS = 16,
   parameter int unsigned TIME_BITS  = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  sjf_cmd_type           cmd,
   output sjf_stat_type          stat,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int unsigned IDX_W   = $clog2(MAX_JOBS);
   localparam int unsigned CNT_W   = $clog2(MAX_JOBS + 1);
   localparam int unsigned ENT_W   = ID_W + BURST_BITS + TIME_BITS;
   localparam int unsigned BURST_LO = ID_W;
   localparam int unsigned STAMP_LO = ID_W + BURST_BITS;

   // Ready table, kept in arrival order.
   logic [ENT_W-1:0] table_mem [MAX_JOBS];

   logic [ID_W-1:0]       job_id_ff;
   logic [BURST_BITS-1:0] burst_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      ptr_ff;
   logic                  rd_vld_ff;
   logic [CNT_W-1:0]      rd_idx_ff;
   logic [ENT_W-1:0]      rd_q_ff;
   logic [ENT_W-1:0]      best_ff;
   logic [CNT_W-1:0]      best_idx_ff;
   logic                  cur_valid_ff;
   logic [ID_W-1:0]       cur_job_ff;
   logic [BURST_BITS-1:0] cur_left_ff;
   logic [TIME_BITS-1:0]  tat_base_ff;
   logic [TIME_BITS-1:0]  wt_base_ff;
   logic [TIME_BITS-1:0]  now_ff;
   logic                  rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff;

   logic                  issue;
   logic                  arrive_ok;
   logic                  mem_we;
   logic [IDX_W-1:0]      mem_waddr;
   logic [ENT_W-1:0]      mem_wdata;
   logic [BURST_BITS-1:0] q_burst;
   logic [BURST_BITS-1:0] best_burst;
   logic [TIME_BITS-1:0]  best_stamp;
   logic [TIME_BITS-1:0]  now_next;
   logic [BURST_BITS-1:0] left_next;
   logic                  done_now;
   logic [TIME_BITS-1:0]  tat;
   logic [TIME_BITS-1:0]  wt;

   assign q_burst    = rd_q_ff[BURST_LO +: BURST_BITS];
   assign best_burst = best_ff[BURST_LO +: BURST_BITS];
   assign best_stamp = best_ff[STAMP_LO +: TIME_BITS];

   // Status toward the controller.
   assign stat.cur_valid = cur_valid_ff;
   assign stat.empty     = (count_ff == '0);
   assign stat.walk_done = (ptr_ff >= count_ff) && !rd_vld_ff;
   assign stat.out_free  = !rsp_tvalid_ff || rsp_tready;

   // Latch the request payload at the accepting edge.
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         job_id_ff <= req_tdata[ID_W-1:0];
         burst_ff  <= BURST_BITS'(req_tdata[ID_W +: IN_BURST_W]);
      end
   end

   assign arrive_ok = (burst_ff != '0) && (count_ff < CNT_W'(MAX_JOBS));

   // Table walk: one read issued per cycle, read data registered and back in the next cycle.
   assign issue = (cmd.scan || cmd.shift) && (ptr_ff < count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         ptr_ff <= '0;
      end else if (cmd.shift_start) begin
         ptr_ff <= best_idx_ff + CNT_W'(1);
      end else if (issue) begin
         ptr_ff <= ptr_ff + CNT_W'(1);
      end
      rd_idx_ff <= ptr_ff;
   end

   // Table write port: arrivals append, compaction moves an entry down one.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = IDX_W'(count_ff);
      mem_wdata = {now_ff, burst_ff, job_id_ff};
      if (cmd.arrive) begin
         mem_we = arrive_ok;
      end else if (cmd.shift && rd_vld_ff) begin
         mem_we    = 1'b1;
         mem_waddr = IDX_W'(rd_idx_ff - CNT_W'(1));
         mem_wdata = rd_q_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      rd_q_ff <= table_mem[IDX_W'(ptr_ff)];
   end

   // Minimum search; a strict compare keeps the earliest arrival on ties.
   always_ff @(posedge clock) begin
      if (cmd.scan && rd_vld_ff) begin
         if ((rd_idx_ff == '0) || (q_burst < best_burst)) begin
            best_ff     <= rd_q_ff;
            best_idx_ff <= rd_idx_ff;
         end
      end
   end

   // Ready count.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.arrive && arrive_ok) begin
         count_ff <= count_ff + CNT_W'(1);
      end else if (cmd.pick) begin
         count_ff <= count_ff - CNT_W'(1);
      end
   end

   // Service arithmetic; the bases are prepared at pick time so that each
   // figure is a single subtract from the current time.
   assign now_next  = now_ff + TIME_BITS'(1);
   assign left_next = cur_left_ff - BURST_BITS'(1);
   assign done_now  = cur_valid_ff && (left_next == '0);
   assign tat       = done_now ? (now_ff - tat_base_ff) : '0;
   assign wt        = done_now ? (now_ff - wt_base_ff) : '0;

   // Running slot and time counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         now_ff       <= '0;
      end else if (cmd.pick) begin
         cur_valid_ff <= 1'b1;
      end else if (cmd.serve) begin
         now_ff <= now_next;
         if (done_now) begin
            cur_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pick) begin
         cur_job_ff  <= best_ff[ID_W-1:0];
         cur_left_ff <= best_burst;
         tat_base_ff <= best_stamp - TIME_BITS'(1);
         wt_base_ff  <= best_stamp + TIME_BITS'(best_burst) - TIME_BITS'(1);
      end else if (cmd.serve && cur_valid_ff) begin
         cur_left_ff <= left_next;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.arrive || cmd.serve) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.arrive) begin
         rsp_tdata_ff <= {5'b0, OUT_W'(now_ff), {OUT_W{1'b0}}, {OUT_W{1'b0}},
                          1'b0, {ID_W{1'b0}}, 1'b0, arrive_ok};
      end else if (cmd.serve) begin
         rsp_tdata_ff <= {5'b0, OUT_W'(now_next), OUT_W'(wt), OUT_W'(tat),
                          done_now, cur_valid_ff ? cur_job_ff : {ID_W{1'b0}},
                          cur_valid_ff, 1'b0};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

[rtl/core/sjf_nonpreemptive_scheduler.sv]
// Top level of the non-preemptive shortest-job-first scheduler.
// Joins the controller (sjf_ctrl) and the datapath (sjf_dpath); uses sjf_pkg.
//
// Channel   Direction  Transfers
// req_*     in         one arrival or one tick per transaction
// rsp_*     out        one result per request transaction
//
// An arrival takes an accepting step and a result step, and so does a tick
// while a job is running or the table is empty. A tick that must choose a
// job walks the table twice through the single read port of the ready
// memory: a scan of all N ready jobs and a compaction that moves each entry
// after the chosen slot k down one (k counted from zero; no entry moves when
// the chosen job is the last entry), then the serve step.
// Reset is synchronous and clears the table count, running slot and time.
// A stalled result holds in the output register; one more request is taken
// meanwhile and finishes once that result has been taken.
module sjf_nonpreemptive_scheduler
   import sjf_pkg::*;
#(
   parameter int unsigned MAX_JOBS   = 16,
   parameter int unsigned BURST_BITS = 16,
   parameter int unsigned TIME_BITS  = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // job_id[7:0], burst_len[23:8]
   input  logic                  req_tuser,   // req_type[0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // accepted[0], running_valid[1], running_job[9:2], job_done[10],
   // turnaround[42:11], waiting[74:43], now_time[106:75], zero fill above
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   sjf_cmd_type  cmd;
   sjf_stat_type stat;

   sjf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   sjf_dpath #(
      .MAX_JOBS   (MAX_JOBS),
      .BURST_BITS (BURST_BITS),
      .TIME_BITS  (TIME_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[rtl/core/sjf_checker.sv]
// Port-level checks for the shortest-job-first scheduler, bound to the top.
// Tracks outstanding transactions and the reported time; uses sjf_pkg.
module sjf_port_checker
   import sjf_pkg::*;
#(
   parameter int unsigned TIME_BITS = 32
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic                  req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int unsigned MASK_BITS = (TIME_BITS < OUT_W) ? TIME_BITS : OUT_W;

   logic             req_acc;
   logic             rsp_acc;
   logic [1:0]       pend_ff;
   logic [OUT_W-1:0] last_now_ff;
   logic [OUT_W-1:0] now_out;
   logic [OUT_W-1:0] step_mask;
   logic [OUT_W-1:0] last_plus;

   assign req_acc   = req_tvalid && req_tready;
   assign rsp_acc   = rsp_tvalid && rsp_tready;
   assign now_out   = rsp_tdata[75 +: OUT_W];
   assign step_mask = OUT_W'((64'(1) << MASK_BITS) - 64'(1));
   assign last_plus = (last_now_ff + OUT_W'(1)) & step_mask;

   // Request transactions not yet answered, and the last reported time.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff     <= '0;
         last_now_ff <= '0;
      end else begin
         pend_ff <= pend_ff + 2'(req_acc) - 2'(rsp_acc);
         if (rsp_acc) begin
            last_now_ff <= now_out;
         end
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed or dropped while stalled");

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= 2'd2)
      else $error("more than two transactions in flight");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_acc |-> pend_ff != 2'd0)
      else $error("result without a request");

   a_time_step: assert property (@(posedge clock) disable iff (reset)
      rsp_acc |-> (now_out == last_now_ff) || (now_out == last_plus))
      else $error("reported time moved by more than one tick");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind sjf_nonpreemptive_scheduler sjf_port_checker #(.TIME_BITS(TIME_BITS)) u_sjf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
